FILE: design/vtp_pkg.sv
// Package for the vertex transform and projection unit.
// Holds fixed-point constants, sequencer state codes and saturation helpers.
// No dependencies.
`default_nettype none

package vtp_pkg;

   localparam int FRAC_BITS = 16;
   localparam int DVD_W = 32 + FRAC_BITS;
   localparam int CNT_W = 6;
   localparam longint ONE_L = 64'sd1 << FRAC_BITS;
   localparam longint NLIM_L = 64'sd1 << (17 + FRAC_BITS);
   localparam longint TINY_LIMIT = ONE_L / 1000000;
   localparam logic signed [34:0] ONE_N = 35'(ONE_L);
   localparam logic signed [34:0] NLIM_N = 35'(NLIM_L);
   localparam logic [32:0] DEPTH_SCALE = 33'h07FFFFFFF;
   localparam logic [12:0] WIDTH_RESET = 13'd640;
   localparam logic [12:0] HEIGHT_RESET = 13'd480;

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_VERTEX = 1'b1;

   localparam logic REG_WIDTH = 1'b0;
   localparam logic REG_HEIGHT = 1'b1;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_MAC  = 5'b00010,
      ST_DIV  = 5'b00100,
      ST_MAP  = 5'b01000,
      ST_DONE = 5'b10000
   } state_type;

   function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
      if (v > 50'sh7FFFFFFF) begin
         return 32'sh7FFFFFFF;
      end else if (v < -50'sh80000000) begin
         return 32'sh80000000;
      end
      return v[31:0];
   endfunction

   function automatic logic signed [15:0] sat16(input logic signed [51:0] v);
      if (v > 52'sh7FFF) begin
         return 16'sh7FFF;
      end else if (v < -52'sh8000) begin
         return 16'sh8000;
      end
      return v[15:0];
   endfunction

   function automatic logic signed [51:0] trunc_scale(input logic signed [68:0] p);
      logic signed [68:0] adj;
      adj = p;
      if (p < 0) begin
         adj = p + 69'sd131071;
      end
      return 52'(adj >>> (FRAC_BITS + 1));
   endfunction

endpackage

`default_nettype wire

FILE: design/vertex_transform_project_unit.sv
// Vertex transform, perspective divide and viewport mapping.
// One shared multiplier and a restoring divider run under a one-hot sequencer.
// Depends on vtp_pkg.
//
//   port group  dir  content
//   req_        in   load coefficient or transform vertex (tuser = cmd)
//   rsp_        out  screen position, depth, triangle flags (tlast = triangle_done)
//   csr_        in   screen_width at 0x0, screen_height at 0x4
//
// A coefficient load goes straight to the hand-off state. A vertex runs through
// multiply-accumulate, long division of x, y and z by w in the one-bit-per-cycle
// divider (skipped when w is zero), viewport mapping and the hand-off.
// req_tready is high only while the sequencer is idle;
// a finished result waits in the output register while the next item is taken.
// Reset loads the identity matrix and default screen size.
`default_nettype none

module vertex_transform_project_unit
   import vtp_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // coef_index[3:0], coef_value[35:4], vertex_x[67:36], vertex_y[99:68],
   // vertex_z[131:100], vertex_w[163:132], zero[167:164]
   input  wire logic [167:0] req_tdata,
   // cmd[0]
   input  wire logic [0:0]   req_tuser,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // screen_x[15:0], screen_y[31:16], depth[62:32], zero[63]
   output logic [63:0]       rsp_tdata,
   // triangle_done
   output logic              rsp_tlast,
   // behind_camera[0], triangle_culled[1]
   output logic [1:0]        rsp_tuser,
   input  wire logic         csr_psel,
   input  wire logic         csr_penable,
   input  wire logic         csr_pwrite,
   input  wire logic [2:0]   csr_paddr,
   input  wire logic [31:0]  csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);

   state_type state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [1:0] sel_ff, sel_in;
   logic cmd_ff, cmd_in;
   logic [15:0][31:0] mat_ff, mat_in;
   logic [3:0][31:0] vec_ff, vec_in;
   logic signed [68:0] prod_ff, prod_in;
   logic signed [49:0] acc_ff, acc_in;
   logic [3:0][31:0] t_ff, t_in;
   logic [2:0][34:0] n_ff, n_in;
   logic [DVD_W-1:0] dvd_ff, dvd_in;
   logic [32:0] rem_ff, rem_in;
   logic [DVD_W-1:0] quo_ff, quo_in;
   logic [15:0] sx_ff, sx_in, sy_ff, sy_in;
   logic [30:0] dz_ff, dz_in;
   logic [1:0] vpos_ff, vpos_in;
   logic allb_ff, allb_in;
   logic [12:0] width_ff, width_in, height_ff, height_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [63:0] rsp_data_ff, rsp_data_in;
   logic rsp_last_ff, rsp_last_in;
   logic [1:0] rsp_user_ff, rsp_user_in;

   logic signed [35:0] mul_a;
   logic signed [32:0] mul_b;
   logic [3:0] pidx;
   logic signed [49:0] acc_sum;
   logic signed [31:0] tw, tsel;
   logic [32:0] wmag;
   logic [31:0] tmag;
   logic unit_w;
   logic [32:0] rem_sh;
   logic ge;
   logic [DVD_W-1:0] quo_nx;
   logic signed [DVD_W:0] qs;
   logic signed [34:0] lim, nval;
   logic behind, done, allb;
   logic wr;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;
   assign rsp_tlast = rsp_last_ff;
   assign rsp_tuser = rsp_user_ff;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_WIDTH) ? {19'd0, width_ff} : {19'd0, height_ff};
   assign wr = csr_psel & csr_penable & csr_pwrite;

   assign prod_in = mul_a * mul_b;
   assign pidx = 4'(cnt_ff - CNT_W'(1));
   assign acc_sum = acc_ff + 50'(prod_ff >>> FRAC_BITS);
   assign tw = $signed(t_ff[3]);
   assign tsel = $signed(t_ff[sel_ff]);
   assign wmag = tw[31] ? 33'(-$signed({tw[31], tw})) : {1'b0, tw};
   assign tmag = tsel[31] ? 32'(-$signed({tsel[31], tsel})) : tsel;
   assign unit_w = ({31'd0, wmag} <= 64'(TINY_LIMIT));
   assign rem_sh = {rem_ff[31:0], dvd_ff[DVD_W-1]};
   assign ge = rem_sh >= wmag;
   assign quo_nx = {quo_ff[DVD_W-2:0], ge};
   assign qs = (tsel[31] ^ tw[31]) ? -$signed({1'b0, quo_nx}) : $signed({1'b0, quo_nx});
   assign lim = (sel_ff == 2'd2) ? ONE_N : NLIM_N;
   assign behind = (tw <= 0);
   assign allb = allb_ff & behind;
   assign done = (vpos_ff >= 2'd2);

   always_comb begin
      if (qs > $signed((DVD_W+1)'(lim))) begin
         nval = lim;
      end else if (qs < -$signed((DVD_W+1)'(lim))) begin
         nval = -lim;
      end else begin
         nval = 35'(qs);
      end
   end

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      sel_in = sel_ff;
      cmd_in = cmd_ff;
      mat_in = mat_ff;
      vec_in = vec_ff;
      acc_in = acc_ff;
      t_in = t_ff;
      n_in = n_ff;
      dvd_in = dvd_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      sx_in = sx_ff;
      sy_in = sy_ff;
      dz_in = dz_ff;
      vpos_in = vpos_ff;
      allb_in = allb_ff;
      width_in = width_ff;
      height_in = height_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_data_in = rsp_data_ff;
      rsp_last_in = rsp_last_ff;
      rsp_user_in = rsp_user_ff;
      mul_a = 36'(signed'(mat_ff[{cnt_ff[1:0], cnt_ff[3:2]}]));
      mul_b = 33'(signed'(vec_ff[cnt_ff[1:0]]));

      if (wr) begin
         if (csr_paddr[2] == REG_WIDTH) begin
            width_in = csr_pwdata[12:0];
         end else begin
            height_in = csr_pwdata[12:0];
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd_in = req_tuser[0];
               cnt_in = '0;
               acc_in = '0;
               if (req_tuser[0] == CMD_LOAD) begin
                  mat_in[req_tdata[3:0]] = req_tdata[35:4];
                  state_in = ST_DONE;
               end else begin
                  vec_in[0] = req_tdata[67:36];
                  vec_in[1] = req_tdata[99:68];
                  vec_in[2] = req_tdata[131:100];
                  vec_in[3] = req_tdata[163:132];
                  state_in = ST_MAC;
               end
            end
         end
         ST_MAC: begin
            if (cnt_ff != '0) begin
               if (pidx[1:0] == 2'd3) begin
                  t_in[pidx[3:2]] = sat32(acc_sum);
                  acc_in = '0;
               end else begin
                  acc_in = acc_sum;
               end
            end
            if (cnt_ff == CNT_W'(16)) begin
               cnt_in = '0;
               sel_in = '0;
               state_in = ST_DIV;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         ST_DIV: begin
            if (cnt_ff == '0) begin
               if (unit_w) begin
                  if (sel_ff == 2'd2 && tsel > 32'sh10000) begin
                     n_in[sel_ff] = ONE_N;
                  end else if (sel_ff == 2'd2 && tsel < -32'sh10000) begin
                     n_in[sel_ff] = -ONE_N;
                  end else begin
                     n_in[sel_ff] = 35'(tsel);
                  end
                  if (sel_ff == 2'd2) begin
                     state_in = ST_MAP;
                  end
                  sel_in = sel_ff + 2'd1;
               end else begin
                  dvd_in = {tmag, FRAC_BITS'(0)};
                  rem_in = '0;
                  quo_in = '0;
                  cnt_in = CNT_W'(1);
               end
            end else begin
               rem_in = ge ? rem_sh - wmag : rem_sh;
               quo_in = quo_nx;
               dvd_in = {dvd_ff[DVD_W-2:0], 1'b0};
               if (cnt_ff == CNT_W'(DVD_W)) begin
                  n_in[sel_ff] = nval;
                  cnt_in = '0;
                  sel_in = sel_ff + 2'd1;
                  if (sel_ff == 2'd2) begin
                     state_in = ST_MAP;
                  end
               end else begin
                  cnt_in = cnt_ff + CNT_W'(1);
               end
            end
         end
         ST_MAP: begin
            case (cnt_ff[1:0])
               2'd0: begin
                  mul_a = 36'($signed(n_ff[0]) + ONE_N);
                  mul_b = $signed({20'd0, width_ff});
               end
               2'd1: begin
                  mul_a = 36'(ONE_N - $signed(n_ff[1]));
                  mul_b = $signed({20'd0, height_ff});
                  sx_in = sat16(trunc_scale(prod_ff));
               end
               2'd2: begin
                  mul_a = 36'($signed(n_ff[2]) + ONE_N);
                  mul_b = $signed(DEPTH_SCALE);
                  sy_in = sat16(trunc_scale(prod_ff));
               end
               default: begin
                  dz_in = 31'(prod_ff >>> (FRAC_BITS + 1));
                  state_in = ST_DONE;
               end
            endcase
            cnt_in = cnt_ff + CNT_W'(1);
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               state_in = ST_IDLE;
               if (cmd_ff == CMD_VERTEX) begin
                  rsp_data_in = {1'b0, dz_ff, sy_ff, sx_ff};
                  rsp_last_in = done;
                  rsp_user_in = {done & allb, behind};
                  if (done) begin
                     vpos_in = '0;
                     allb_in = 1'b1;
                  end else begin
                     vpos_in = vpos_ff + 2'd1;
                     allb_in = allb;
                  end
               end else begin
                  rsp_data_in = '0;
                  rsp_last_in = 1'b0;
                  rsp_user_in = '0;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff <= '0;
         sel_ff <= '0;
         vpos_ff <= '0;
         allb_ff <= 1'b1;
         width_ff <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < 16; i++) begin
            mat_ff[i] <= (i % 5 == 0) ? 32'(ONE_L) : 32'd0;
         end
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         sel_ff <= sel_in;
         vpos_ff <= vpos_in;
         allb_ff <= allb_in;
         width_ff <= width_in;
         height_ff <= height_in;
         rsp_valid_ff <= rsp_valid_in;
         mat_ff <= mat_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      vec_ff <= vec_in;
      prod_ff <= prod_in;
      acc_ff <= acc_in;
      t_ff <= t_in;
      n_ff <= n_in;
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      sx_ff <= sx_in;
      sy_ff <= sy_in;
      dz_ff <= dz_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
      rsp_user_ff <= rsp_user_in;
   end

endmodule

`default_nettype wire
